// ===== rtl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg: shared constants for the LRU key/value cache
// Field widths, configuration register map and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

  localparam int unsigned KEY_W         = 32;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned CAP_W         = 5;
  localparam int unsigned MAX_ENTRIES_DEF = 16;

  // APB register map
  localparam int unsigned APB_AW        = 2;
  localparam int unsigned APB_DW        = 32;
  localparam logic [APB_AW-1:0] ADDR_CAPACITY = 2'd0;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/lkvc_req_if.sv =====
// ----------------------------------------------------------------------------
// lkvc_req_if: request channel of the LRU key/value cache
// Carries one get or put word with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lkvc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [lkvc_pkg::KEY_W-1:0]  key;
  logic [lkvc_pkg::VAL_W-1:0]  value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/lkvc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lkvc_rsp_if: response channel of the LRU key/value cache
// Carries one result word per request with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lkvc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [lkvc_pkg::VAL_W-1:0]  read_value;
  logic                        evicted;
  logic [lkvc_pkg::KEY_W-1:0]  evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

`default_nettype wire

// ===== rtl/lkvc_cell.sv =====
// ----------------------------------------------------------------------------
// lkvc_cell: one entry of the cache chain
// Holds key, value, valid mark and recency rank; merges its own match, free
// and victim status into the scan word passed on to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkvc_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 4,
  parameter type         scan_t = logic,
  parameter type         upd_t  = logic
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire scan_t                       scan_i,
  output scan_t                            scan_o,
  input  wire logic [lkvc_pkg::KEY_W-1:0]  look_key_i,
  input  wire logic [IW-1:0]               last_rank_i,
  input  wire upd_t                        upd_i
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                       valid_q, valid_d;
  logic [IW-1:0]              rank_q, rank_d;
  logic [lkvc_pkg::KEY_W-1:0] key_q;
  logic [lkvc_pkg::VAL_W-1:0] val_q;
  logic                       wr_key, wr_val;
  scan_t                      scan_d, scan_q;

  // scan merge: first match, first free slot, least recent entry
  always_comb begin
    scan_d = scan_i;
    if (valid_q && key_q == look_key_i && !scan_i.found) begin
      scan_d.found     = 1'b1;
      scan_d.hit_idx   = MY_IDX;
      scan_d.hit_rank  = rank_q;
      scan_d.hit_value = val_q;
    end
    if (!valid_q && !scan_i.free_found) begin
      scan_d.free_found = 1'b1;
      scan_d.free_idx   = MY_IDX;
    end
    if (valid_q && rank_q == last_rank_i) begin
      scan_d.vic_idx = MY_IDX;
      scan_d.vic_key = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
  end

  assign scan_o = scan_q;

  // update: broadcast command applied by every cell at once
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    wr_key  = 1'b0;
    wr_val  = 1'b0;
    if (upd_i.en) begin
      if (upd_i.tgt == MY_IDX) begin
        rank_d = '0;
        if (!upd_i.is_hit) begin
          valid_d = 1'b1;
          wr_key  = 1'b1;
          wr_val  = 1'b1;
        end else begin
          wr_val = upd_i.is_put;
        end
      end else if (valid_q && (!upd_i.is_hit || rank_q < upd_i.limit)) begin
        rank_d = rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_key) begin
      key_q <= upd_i.key;
    end
    if (wr_val) begin
      val_q <= upd_i.value;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value store, LRU replacement
// Entries sit in a chain of cells; a scan word ripples down it, then one
// broadcast update rewrites keys, values and recency ranks.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : request word (op 0 = get, op 1 = put, key, value), valid/ready.
//   rsp_o  : one result word per request (hit, read_value, evicted,
//            evicted_key), valid/ready, held in an output register.
//   APB    : capacity at address 0 (5 bits, reset 16); write only while idle.
// Timing:
//   A request is accepted in the idle state. The scan word passes one cell
//   per cycle through the scan state; the update state then loads the output
//   register and returns to idle. A new request is taken only once the last
//   one has finished its update; the scan chain length sets the lookup time.
// Reset:
//   All valid marks, ranks and the entry count clear at once; no sweep.
// Back-pressure:
//   A waiting result does not block acceptance or the scan of the next
//   request; that request holds in its update cycle until the output
//   register is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  lkvc_req_if.sink                          req_i,
  lkvc_rsp_if.source                        rsp_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lkvc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [lkvc_pkg::APB_DW-1:0]  pwdata,
  output logic      [lkvc_pkg::APB_DW-1:0]  prdata,
  output logic                              pready
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned UW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW = (UW > lkvc_pkg::CAP_W) ? UW : lkvc_pkg::CAP_W;
  localparam int unsigned KW = lkvc_pkg::KEY_W;
  localparam int unsigned VW = lkvc_pkg::VAL_W;

  typedef struct packed {
    logic          found;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] hit_rank;
    logic [VW-1:0] hit_value;
    logic          free_found;
    logic [IW-1:0] free_idx;
    logic [IW-1:0] vic_idx;
    logic [KW-1:0] vic_key;
  } scan_t;

  typedef struct packed {
    logic          en;
    logic          is_hit;
    logic          is_put;
    logic [IW-1:0] tgt;
    logic [IW-1:0] limit;
    logic [KW-1:0] key;
    logic [VW-1:0] value;
  } upd_t;

  // ---------------- configuration ----------------
  logic [lkvc_pkg::CAP_W-1:0] cap_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == lkvc_pkg::ADDR_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[lkvc_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == lkvc_pkg::ADDR_CAPACITY) begin
      prdata = lkvc_pkg::APB_DW'(cap_q);
    end
  end

  // ---------------- control ----------------
  lkvc_pkg::state_e   state_q, state_d;
  logic [IW-1:0]      cnt_q, cnt_d;
  logic [UW-1:0]      used_q, used_d;
  logic               op_q;
  logic [KW-1:0]      key_q;
  logic [VW-1:0]      val_q;
  logic               out_vld_q, out_vld_d;
  logic               out_hit_q, out_ev_q;
  logic [VW-1:0]      out_rd_q;
  logic [KW-1:0]      out_evk_q;
  logic               accept, fire;
  logic [CW-1:0]      cap_ext, eff_cap;
  logic               evict;
  logic [IW-1:0]      last_rank;
  scan_t              chain [MAX_ENTRIES+1];
  scan_t              res;
  upd_t               upd;

  assign req_i.ready = (state_q == lkvc_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign fire        = (state_q == lkvc_pkg::ST_UPD) && (!out_vld_q || rsp_o.ready);

  // effective capacity: zero reads as one, clamp to the entry count
  assign cap_ext = CW'(cap_q);
  always_comb begin
    priority if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(MAX_ENTRIES)) begin
      eff_cap = CW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign evict     = CW'(used_q) >= eff_cap;
  assign last_rank = IW'(used_q - 1'b1);
  assign chain[0]  = '0;
  assign res       = chain[MAX_ENTRIES];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          state_d = lkvc_pkg::ST_SCAN;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IW'(MAX_ENTRIES - 1)) begin
          state_d = lkvc_pkg::ST_UPD;
        end
      end
      lkvc_pkg::ST_UPD: begin
        if (fire) begin
          state_d = lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  // update command from the finished scan word
  always_comb begin
    upd.en     = fire && (res.found || op_q);
    upd.is_hit = res.found;
    upd.is_put = op_q;
    upd.limit  = res.hit_rank;
    upd.key    = key_q;
    upd.value  = val_q;
    priority if (res.found) begin
      upd.tgt = res.hit_idx;
    end else if (evict) begin
      upd.tgt = res.vic_idx;
    end else begin
      upd.tgt = res.free_idx;
    end
  end

  always_comb begin
    used_d = used_q;
    if (fire && !res.found && op_q && !evict) begin
      used_d = used_q + 1'b1;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lkvc_pkg::ST_IDLE;
      cnt_q     <= '0;
      used_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      used_q    <= used_d;
      out_vld_q <= out_vld_d;
    end
  end

  // hold the request word for the scan and update
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.op;
      key_q <= req_i.key;
      val_q <= req_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_hit_q <= res.found;
      out_ev_q  <= !res.found && op_q && evict;
      out_evk_q <= (!res.found && op_q && evict) ? res.vic_key : '0;
      priority if (op_q) begin
        out_rd_q <= '0;
      end else if (res.found) begin
        out_rd_q <= res.hit_value;
      end else begin
        out_rd_q <= lkvc_pkg::MISS_VALUE;
      end
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.read_value  = out_rd_q;
  assign rsp_o.evicted     = out_ev_q;
  assign rsp_o.evicted_key = out_evk_q;

  // ---------------- cell chain ----------------
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lkvc_cell #(
      .IDX    (g),
      .IW     (IW),
      .scan_t (scan_t),
      .upd_t  (upd_t)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .scan_i      (chain[g]),
      .scan_o      (chain[g+1]),
      .look_key_i  (key_q),
      .last_rank_i (last_rank),
      .upd_i       (upd)
    );
  end

endmodule

`default_nettype wire

// ===== rtl/lkvc_checker.sv =====
// ----------------------------------------------------------------------------
// lkvc_checker: port-level checks for the LRU key/value cache
// Watches the response channel for result words that cannot occur.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkvc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        rsp_valid_i,
  input wire logic                        rsp_ready_i,
  input wire logic                        rsp_hit_i,
  input wire logic [lkvc_pkg::VAL_W-1:0]  rsp_read_value_i,
  input wire logic                        rsp_evicted_i,
  input wire logic [lkvc_pkg::KEY_W-1:0]  rsp_evicted_key_i
);

  // eviction only on an inserting put, never on a hit
  a_no_evict_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_hit_i && rsp_evicted_i))
    else $error("eviction reported on a hit");

  a_evkey_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_evicted_i) |-> (rsp_evicted_key_i == '0))
    else $error("evicted key not zero without eviction");

  // a miss reads all ones on a get, zero on a put
  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_hit_i) |->
      (rsp_read_value_i == lkvc_pkg::MISS_VALUE || rsp_read_value_i == '0))
    else $error("miss returned a stored value");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_hit_i) && $stable(rsp_read_value_i)
       && $stable(rsp_evicted_i) && $stable(rsp_evicted_key_i)))
    else $error("result word changed while stalled");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_hit_i         (rsp_o.hit),
  .rsp_read_value_i  (rsp_o.read_value),
  .rsp_evicted_i     (rsp_o.evicted),
  .rsp_evicted_key_i (rsp_o.evicted_key)
);

`default_nettype wire

// ===== tb/tb_lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache: self-checking bench for the LRU key/value cache
// A directed table covers the key and value extremes, get misses, stored -1,
// updates and capacity lowered below the entries in use. Random phases then
// run gets and puts over small key pools at several capacities, with random
// stalls on both channels and one long response hold-off. Every result word
// is checked against the table's expected word or an in-bench LRU predictor.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;

  localparam int unsigned SLOTS        = lkvc_pkg::MAX_ENTRIES_DEF;
  localparam int unsigned RANK_W       = $clog2(SLOTS);
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_WORDS  = 200;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned DIR_ROWS     = 22;

  localparam logic [lkvc_pkg::VAL_W-1:0] MISS_RD = lkvc_pkg::MISS_VALUE;

  typedef enum logic {OP_GET = 1'b0, OP_PUT = 1'b1} cache_op_e;
  typedef enum logic {ROW_WORD = 1'b0, ROW_CAPACITY = 1'b1} row_kind_e;

  typedef struct packed {
    logic                       hit;
    logic [lkvc_pkg::VAL_W-1:0] read_value;
    logic                       evicted;
    logic [lkvc_pkg::KEY_W-1:0] evicted_key;
  } cache_result_t;

  // for capacity rows the new capacity sits in value
  typedef struct packed {
    row_kind_e                  kind;
    cache_op_e                  op;
    logic [lkvc_pkg::KEY_W-1:0] key;
    logic [lkvc_pkg::VAL_W-1:0] value;
    logic                       typed;
    cache_result_t              exp;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_WORD, OP_GET, 32'h0000_0000, 32'hDEAD_BEEF, 1'b1, '{1'b0, MISS_RD, 1'b0, 32'h0}},
    '{ROW_WORD, OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{ROW_WORD, OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{ROW_WORD, OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
    '{ROW_WORD, OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
    '{ROW_WORD, OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{ROW_WORD, OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
    '{ROW_WORD, OP_PUT, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 1'b0, 32'h0}},
    '{ROW_WORD, OP_GET, 32'h8000_0000, 32'h5555_AAAA, 1'b1, '{1'b1, 32'h0, 1'b0, 32'h0}},
    '{ROW_WORD, OP_PUT, 32'h0000_0000, 32'h1234_5678, 1'b0, '0},
    // four in use, capacity drops to two
    '{ROW_CAPACITY, OP_GET, 32'h0, 32'd2, 1'b0, '0},
    '{ROW_WORD, OP_PUT, 32'h0000_0005, 32'h0000_0005, 1'b1, '{1'b0, 32'h0, 1'b1, 32'h7FFF_FFFF}},
    '{ROW_WORD, OP_PUT, 32'h0000_0006, 32'h0000_0006, 1'b1, '{1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF}},
    '{ROW_WORD, OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, MISS_RD, 1'b0, 32'h0}},
    '{ROW_WORD, OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_WORD, OP_PUT, 32'h0000_0007, 32'hA5A5_5A5A, 1'b0, '0},
    '{ROW_CAPACITY, OP_GET, 32'h0, 32'd1, 1'b0, '0},
    '{ROW_WORD, OP_PUT, 32'h0000_0008, 32'h0000_0008, 1'b0, '0},
    '{ROW_WORD, OP_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, '0},
    '{ROW_WORD, OP_PUT, 32'h0000_0008, 32'h0000_0009, 1'b0, '0},
    '{ROW_CAPACITY, OP_GET, 32'h0, 32'd16, 1'b0, '0},
    '{ROW_WORD, OP_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, '0}
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [lkvc_pkg::APB_AW-1:0] paddr;
  logic [lkvc_pkg::APB_DW-1:0] pwdata;
  logic [lkvc_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  lkvc_req_if req_bus ();
  lkvc_rsp_if rsp_bus ();

  lru_key_value_cache DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [lkvc_pkg::KEY_W-1:0] key_mem    [SLOTS];
  logic [lkvc_pkg::VAL_W-1:0] val_mem    [SLOTS];
  bit                         slot_valid [SLOTS];
  logic [RANK_W-1:0]          slot_rank  [SLOTS];
  logic [lkvc_pkg::CAP_W-1:0] slots_used;
  logic [lkvc_pkg::CAP_W-1:0] capacity_reg;

  cache_result_t pending_results [$];
  int unsigned   err_count;
  int unsigned   quiet_cycles;
  bit            idle_on;
  bit            long_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // make slot s most recent; valid slots ranked below limit age by one
  function automatic void promote_slot(int s, int limit);
    for (int i = 0; i < SLOTS; i++) begin
      if (i != s && slot_valid[i] && int'(slot_rank[i]) < limit) slot_rank[i] += 1'b1;
    end
    slot_rank[s] = '0;
  endfunction

  function automatic cache_result_t cache_access(cache_op_e op,
                                                 logic [lkvc_pkg::KEY_W-1:0] key,
                                                 logic [lkvc_pkg::VAL_W-1:0] val);
    cache_result_t res;
    int            slot;
    int            eff_cap;
    int            best;
    bit            found;
    bit            free_found;
    bit            any;
    res   = '0;
    slot  = 0;
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && slot_valid[i] && key_mem[i] == key) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      res.hit = 1'b1;
      if (op == OP_GET) res.read_value = val_mem[slot];
      else val_mem[slot] = val;
      promote_slot(slot, int'(slot_rank[slot]));
    end else if (op == OP_GET) begin
      res.read_value = lkvc_pkg::MISS_VALUE;
    end else begin
      eff_cap = (capacity_reg == 0) ? 1 : int'(capacity_reg);
      if (eff_cap > SLOTS) eff_cap = SLOTS;
      free_found = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!free_found && !slot_valid[i]) begin
          free_found = 1'b1;
          slot       = i;
        end
      end
      if (int'(slots_used) >= eff_cap || !free_found) begin
        // evict the oldest valid slot, lowest index on a tie
        any  = 1'b0;
        best = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && (!any || int'(slot_rank[i]) > best)) begin
            any  = 1'b1;
            best = int'(slot_rank[i]);
            slot = i;
          end
        end
        if (any) begin
          res.evicted     = 1'b1;
          res.evicted_key = key_mem[slot];
          slot_valid[slot] = 1'b0;
          slots_used -= 1'b1;
        end
      end
      key_mem[slot] = key;
      val_mem[slot] = val;
      promote_slot(slot, SLOTS);
      slot_valid[slot] = 1'b1;
      slots_used += 1'b1;
    end
    return res;
  endfunction

  // write the capacity once the cache has drained, then read it back
  task automatic set_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = lkvc_pkg::ADDR_CAPACITY;
    pwdata  = lkvc_pkg::APB_DW'(cap);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    capacity_reg = cap;
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== lkvc_pkg::APB_DW'(cap)) begin
      $error("capacity readback: expected %0d, got %0d", cap, prdata);
      err_count++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // offer one request word; called and returns at a falling edge
  task automatic send_word(input cache_op_e op, input logic [lkvc_pkg::KEY_W-1:0] key,
                           input logic [lkvc_pkg::VAL_W-1:0] val, input bit typed,
                           input cache_result_t exp);
    cache_result_t predicted;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_bus.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    req_bus.op    = op;
    req_bus.key   = key;
    req_bus.value = val;
    req_bus.valid = 1'b1;
    do @(posedge clk_i); while (!req_bus.ready);
    predicted = cache_access(op, key, val);
    pending_results.push_back(typed ? exp : predicted);
    @(negedge clk_i);
  endtask

  // response side: random stalls, plus one long hold on request
  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        rsp_bus.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold_req = 1'b0;
        stall_left    = 0;
      end else if (stall_left != 0) begin
        rsp_bus.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rsp_bus.ready = 1'b0;
        stall_left    = $urandom_range(1, 19) - 1;
      end else begin
        rsp_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cache_result_t want;
    if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing outstanding");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, rsp_bus.hit);
          err_count++;
        end
        if (rsp_bus.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, rsp_bus.read_value);
          err_count++;
        end
        if (rsp_bus.evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, rsp_bus.evicted);
          err_count++;
        end
        if (rsp_bus.evicted_key !== want.evicted_key) begin
          $error("evicted_key: expected %h, got %h", want.evicted_key, rsp_bus.evicted_key);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_lru_key_value_cache: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [lkvc_pkg::KEY_W-1:0] pool [40];
    int unsigned                pool_size;
    int unsigned                eff;
    logic [lkvc_pkg::CAP_W-1:0] cap;
    logic [lkvc_pkg::KEY_W-1:0] key;
    cache_op_e                  op;

    rst_ni        = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.op    = OP_GET;
    req_bus.key   = '0;
    req_bus.value = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = lkvc_pkg::ADDR_CAPACITY;
    pwdata        = '0;
    err_count     = 0;
    quiet_cycles  = 0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    slots_used    = '0;
    capacity_reg  = lkvc_pkg::CAP_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_rank[i]  = '0;
    end

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CAPACITY) begin
        req_bus.valid = 1'b0;
        set_capacity(dir_rows[r].value[lkvc_pkg::CAP_W-1:0]);
      end else begin
        send_word(dir_rows[r].op, dir_rows[r].key, dir_rows[r].value, dir_rows[r].typed,
                  dir_rows[r].exp);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      req_bus.valid = 1'b0;
      case (p)
        0, 3, 7: cap = 5'd16;
        1:       cap = 5'd1;
        4:       cap = 5'd3;
        6:       cap = 5'd2;
        default: cap = lkvc_pkg::CAP_W'($urandom_range(1, 16));
      endcase
      set_capacity(cap);
      if (p == 3) long_hold_req = 1'b1;
      if (p == PHASES - 1) idle_on = 1'b0;
      // pool a little larger than the capacity: a mix of hits and evictions
      eff       = cap;
      pool_size = eff + $urandom_range(1, eff + 3);
      for (int i = 0; i < pool_size; i++) pool[i] = $urandom;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else key = pool[$urandom_range(0, pool_size - 1)];
        op = ($urandom_range(0, 99) < 45) ? OP_PUT : OP_GET;
        send_word(op, key, $urandom, 1'b0, '0);
      end
    end
    req_bus.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_lru_key_value_cache: clean");
    end else begin
      $display("tb_lru_key_value_cache: errors");
    end
    $finish;
  end

endmodule
